@@ rtl/core/bgab_pkg.sv @@
// bgab_pkg: shared types, constants and helpers for the gradient fill block
// no dependencies; used by the top level and the testbench
`default_nettype none

package bgab_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIV_STEPS = 21;
	localparam int NUM_REGS = 7;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_COLOR_UL = 3'd0,
		REG_COLOR_UR = 3'd1,
		REG_COLOR_LL = 3'd2,
		REG_COLOR_LR = 3'd3,
		REG_RECT     = 3'd4,
		REG_CLIP     = 3'd5,
		REG_BLEND    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] dest_red;
		logic [7:0] dest_green;
		logic [7:0] dest_blue;
	} dest_req_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       last_pixel;
	} pix_rsp_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [47:0] value;
	} cfg_req_t;

	// sequencer states
	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_LOAD    = 8'b0000_0010,
		S_DIV     = 8'b0000_0100,
		S_MUL     = 8'b0000_1000,
		S_ADD     = 8'b0001_0000,
		S_BLEND_A = 8'b0010_0000,
		S_BLEND_B = 8'b0100_0000,
		S_DONE    = 8'b1000_0000
	} state_t;

	// clamp a 20-bit two's complement 12.8 colour to 0..65535
	function automatic logic [15:0] sat16(input logic [19:0] v);
		logic [15:0] r;
		if (v[19]) begin
			r = 16'd0;
		end else if (|v[18:16]) begin
			r = 16'hFFFF;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/bgab_chan_if.sv @@
// bgab_chan_if: valid/ready channel carrying one payload request
// payload type handed in as a parameter, usually from bgab_pkg
`default_nettype none

interface bgab_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bilinear_gradient_alpha_blend.sv @@
// bilinear_gradient_alpha_blend: bilinear RGBA gradient fill with alpha blend
// depends on bgab_pkg and bgab_chan_if
// plain pixel: blend per colour channel, result registered once the output is free, then back to idle
// column start first runs, for each of 4 channels, load, 21 divider steps, multiply and add
// frame start first runs the same sequence for the 8 horizontal steps
// one request in flight; arst_n clears configuration registers, indices and sequencer; result held until taken
`default_nettype none

module bilinear_gradient_alpha_blend #(
	parameter int MaxDim = bgab_pkg::MAX_DIM
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bgab_chan_if.sink   cfg,
	bgab_chan_if.sink   dest_in,
	bgab_chan_if.source pix_out
);

	typedef bgab_pkg::pix_rsp_t pix_rsp_t;

	// configuration registers
	logic [31:0] cul_q, cur_q, cll_q, clr_q;
	logic [25:0] rect_q;
	logic [47:0] clip_q;
	logic        blend_q;

	// walk and interpolation state
	bgab_pkg::state_t state_q;
	logic [11:0] col_q, row_q;
	logic [19:0] top_q [4];
	logic [19:0] bot_q [4];
	logic [19:0] hstep_q [8];
	logic [19:0] vstep_q [4];
	logic [19:0] pix_q [4];
	logic        col_phase_q;
	logic [2:0]  ch_q;
	logic [7:0]  dest_q [3];
	logic [7:0]  res_q [3];

	// shared divider
	logic [12:0] rem_q;
	logic [20:0] quo_q;
	logic        neg_q;
	logic [4:0]  div_cnt_q;

	// shared multiplier result
	logic [31:0] prod_q;

	// output register
	logic     out_v_q;
	pix_rsp_t out_q;

	logic [12:0] w, h;
	logic [11:0] ox, oy, dw, dh;
	logic        empty, solid, wrap;
	logic [11:0] col_z, row_z;
	logic [1:0]  k;
	logic [7:0]  lbyte, rbyte;
	logic signed [8:0]  hnum;
	logic [7:0]  hmag;
	logic signed [20:0] vnum;
	logic [20:0] vmag;
	logic [13:0] div_sh;
	logic [13:0] div_diff;
	logic [12:0] den;
	logic [20:0] quo_neg;
	logic [19:0] q20;
	logic [19:0] mul_a;
	logic [11:0] mul_b;
	logic [31:0] prod;
	logic [15:0] c_k;
	logic [15:0] a_sat;
	logic [7:0]  a8;
	logic [24:0] blend_sum;
	logic [12:0] row_n, col_n;
	logic        out_free;

	assign w  = rect_q[12:0];
	assign h  = rect_q[25:13];
	assign ox = clip_q[11:0];
	assign oy = clip_q[23:12];
	assign dw = clip_q[35:24];
	assign dh = clip_q[47:36];

	assign empty = (w == 13'd0) || (h == 13'd0) || (w > 13'(MaxDim)) || (h > 13'(MaxDim))
		|| (dw == 12'd0) || (dh == 12'd0);
	assign solid = (cul_q[23:0] == cur_q[23:0]) && (cul_q[23:0] == cll_q[23:0])
		&& (cul_q[23:0] == clr_q[23:0]);

	// walk position after frame wrap
	assign wrap  = (col_q >= dw) || (row_q >= dh);
	assign col_z = wrap ? 12'd0 : col_q;
	assign row_z = wrap ? 12'd0 : row_q;

	// corner bytes for the horizontal step of the current channel
	assign k     = ch_q[1:0];
	assign lbyte = ch_q[2] ? cll_q[8*k +: 8] : cul_q[8*k +: 8];
	assign rbyte = ch_q[2] ? clr_q[8*k +: 8] : cur_q[8*k +: 8];
	assign hnum  = $signed({1'b0, rbyte}) - $signed({1'b0, lbyte});
	assign hmag  = hnum[8] ? 8'(-hnum) : hnum[7:0];
	assign vnum  = $signed({bot_q[k][19], bot_q[k]}) - $signed({top_q[k][19], top_q[k]});
	assign vmag  = vnum[20] ? 21'(-vnum) : 21'(vnum);

	// restoring divide step
	assign den      = col_phase_q ? h : w;
	assign div_sh   = {rem_q, quo_q[20]};
	assign div_diff = div_sh - {1'b0, den};
	assign quo_neg  = ~quo_q + 21'd1;
	assign q20      = neg_q ? quo_neg[19:0] : quo_q[19:0];

	// blend operands
	assign c_k   = bgab_pkg::sat16(pix_q[k]);
	assign a_sat = bgab_pkg::sat16(pix_q[3]);
	assign a8    = a_sat[15:8];

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			bgab_pkg::S_MUL: begin
				mul_a = q20;
				mul_b = col_phase_q ? oy : ox;
			end
			bgab_pkg::S_BLEND_A: begin
				mul_a = {4'd0, c_k};
				mul_b = {4'd0, a8};
			end
			bgab_pkg::S_BLEND_B: begin
				mul_a = {4'd0, dest_q[k], 8'd0};
				mul_b = {4'd0, 8'd255 - a8};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod      = 32'(mul_a) * 32'(mul_b);
	assign blend_sum = prod_q[24:0] + prod[24:0];

	assign row_n    = {1'b0, row_q} + 13'd1;
	assign col_n    = {1'b0, col_q} + 13'd1;
	assign out_free = !out_v_q || pix_out.ready;

	assign cfg.ready     = 1'b1;
	assign dest_in.ready = (state_q == bgab_pkg::S_IDLE);
	assign pix_out.valid = out_v_q;
	assign pix_out.data  = out_q;

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			bgab_pkg::S_IDLE: begin
				dest_q[0] <= dest_in.data.dest_red;
				dest_q[1] <= dest_in.data.dest_green;
				dest_q[2] <= dest_in.data.dest_blue;
			end
			bgab_pkg::S_MUL: begin
				prod_q <= prod;
				if (col_phase_q) begin
					vstep_q[k] <= q20;
				end else begin
					hstep_q[ch_q] <= q20;
				end
			end
			bgab_pkg::S_BLEND_A: begin
				prod_q <= prod;
			end
			bgab_pkg::S_BLEND_B: begin
				res_q[k] <= (blend_q && !solid) ? blend_sum[23:16] : c_k[15:8];
			end
			default: begin
			end
		endcase
	end

	// sequencer, walk state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bgab_pkg::S_IDLE;
			cul_q       <= '0;
			cur_q       <= '0;
			cll_q       <= '0;
			clr_q       <= '0;
			rect_q      <= '0;
			clip_q      <= '0;
			blend_q     <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			col_phase_q <= 1'b0;
			ch_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			neg_q       <= 1'b0;
			div_cnt_q   <= '0;
			out_v_q     <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < 4; i++) begin
				top_q[i] <= '0;
				bot_q[i] <= '0;
				pix_q[i] <= '0;
			end
		end else begin
			if (pix_out.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				// take a request and pick the set-up needed
				bgab_pkg::S_IDLE: begin
					if (dest_in.valid && !empty) begin
						col_q <= col_z;
						row_q <= row_z;
						ch_q  <= '0;
						if (col_z == 12'd0 && row_z == 12'd0) begin
							col_phase_q <= 1'b0;
							state_q     <= bgab_pkg::S_LOAD;
						end else if (row_z == 12'd0) begin
							col_phase_q <= 1'b1;
							state_q     <= bgab_pkg::S_LOAD;
						end else begin
							state_q <= bgab_pkg::S_BLEND_A;
						end
					end
				end
				// load divider with a signed numerator as sign and magnitude
				bgab_pkg::S_LOAD: begin
					rem_q     <= '0;
					div_cnt_q <= '0;
					if (col_phase_q) begin
						neg_q <= vnum[20];
						quo_q <= vmag;
					end else begin
						neg_q <= hnum[8];
						quo_q <= {5'd0, hmag, 8'd0};
					end
					state_q <= bgab_pkg::S_DIV;
				end
				bgab_pkg::S_DIV: begin
					if (!div_diff[13]) begin
						rem_q <= div_diff[12:0];
						quo_q <= {quo_q[19:0], 1'b1};
					end else begin
						rem_q <= div_sh[12:0];
						quo_q <= {quo_q[19:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(bgab_pkg::DIV_STEPS - 1)) begin
						state_q <= bgab_pkg::S_MUL;
					end
				end
				bgab_pkg::S_MUL: begin
					state_q <= bgab_pkg::S_ADD;
				end
				// offset the edge or pixel start by step times clip offset
				bgab_pkg::S_ADD: begin
					if (col_phase_q) begin
						pix_q[k] <= top_q[k] + prod_q[19:0];
						if (ch_q == 3'd3) begin
							ch_q    <= '0;
							state_q <= bgab_pkg::S_BLEND_A;
						end else begin
							ch_q    <= ch_q + 3'd1;
							state_q <= bgab_pkg::S_LOAD;
						end
					end else begin
						if (ch_q[2]) begin
							bot_q[k] <= {4'd0, lbyte, 8'd0} + prod_q[19:0];
						end else begin
							top_q[k] <= {4'd0, lbyte, 8'd0} + prod_q[19:0];
						end
						if (ch_q == 3'd7) begin
							col_phase_q <= 1'b1;
							ch_q        <= '0;
						end else begin
							ch_q <= ch_q + 3'd1;
						end
						state_q <= bgab_pkg::S_LOAD;
					end
				end
				bgab_pkg::S_BLEND_A: begin
					state_q <= bgab_pkg::S_BLEND_B;
				end
				bgab_pkg::S_BLEND_B: begin
					if (ch_q == 3'd2) begin
						state_q <= bgab_pkg::S_DONE;
					end else begin
						ch_q    <= ch_q + 3'd1;
						state_q <= bgab_pkg::S_BLEND_A;
					end
				end
				// present result and step the walk
				bgab_pkg::S_DONE: begin
					if (out_free) begin
						out_v_q          <= 1'b1;
						out_q.out_red    <= res_q[0];
						out_q.out_green  <= res_q[1];
						out_q.out_blue   <= res_q[2];
						out_q.last_pixel <= (col_q == dw - 12'd1) && (row_q == dh - 12'd1);
						for (int i = 0; i < 4; i++) begin
							pix_q[i] <= pix_q[i] + vstep_q[i];
						end
						if (row_n >= {1'b0, dh}) begin
							row_q <= '0;
							for (int i = 0; i < 4; i++) begin
								top_q[i] <= top_q[i] + hstep_q[i];
								bot_q[i] <= bot_q[i] + hstep_q[i+4];
							end
							col_q <= (col_n >= {1'b0, dw}) ? 12'd0 : col_n[11:0];
						end else begin
							row_q <= row_n[11:0];
						end
						state_q <= bgab_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= bgab_pkg::S_IDLE;
				end
			endcase
			// register writes restart the frame
			if (cfg.valid) begin
				case (cfg.data.index)
					bgab_pkg::REG_COLOR_UL: cul_q <= cfg.data.value[31:0];
					bgab_pkg::REG_COLOR_UR: cur_q <= cfg.data.value[31:0];
					bgab_pkg::REG_COLOR_LL: cll_q <= cfg.data.value[31:0];
					bgab_pkg::REG_COLOR_LR: clr_q <= cfg.data.value[31:0];
					bgab_pkg::REG_RECT:     rect_q <= cfg.data.value[25:0];
					bgab_pkg::REG_CLIP:     clip_q <= cfg.data.value;
					bgab_pkg::REG_BLEND:    blend_q <= cfg.data.value[0];
					default: begin
					end
				endcase
				if (cfg.data.index < 3'(bgab_pkg::NUM_REGS)) begin
					col_q <= '0;
					row_q <= '0;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// divider never runs past its step count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgab_pkg::S_DIV) |-> (div_cnt_q < 5'(bgab_pkg::DIV_STEPS)))
		else $error("divider step count overrun");

	// column set-up only walks the four channels
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgab_pkg::S_LOAD && col_phase_q) |-> (ch_q < 3'd4))
		else $error("column set-up channel out of range");

	// a finished pixel lies inside the drawn window
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgab_pkg::S_DONE && !cfg.valid) |-> (col_q < dw && row_q < dh))
		else $error("walk position outside drawn window");

	// a new result only replaces one that has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !pix_out.ready) |=> (out_v_q && $stable(out_q)))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ verif/bilinear_gradient_alpha_blend_test.sv @@
`timescale 1ns / 1ps
// bilinear_gradient_alpha_blend_test: self-checking bench for the gradient fill block
// drives config, destination and pixel channels; predicts each pixel in a scoreboard class
// depends on bgab_pkg, bgab_chan_if and bilinear_gradient_alpha_blend
`default_nettype none

module bilinear_gradient_alpha_blend_test;

	localparam logic [2:0] UNUSED_REG_IDX = 3'(bgab_pkg::NUM_REGS);
	localparam int PIPE_QUIET = 400;

	// gradient predictor and store of expected pixels
	class pixel_scoreboard;
		logic [31:0] corner[4];
		logic [25:0] rect;
		logic [47:0] clip;
		logic        blend;
		int          col;
		int          row;
		logic [19:0] top_acc[4];
		logic [19:0] bot_acc[4];
		logic [19:0] hstep[8];
		logic [19:0] vstep[4];
		logic [19:0] pix_acc[4];
		bgab_pkg::pix_rsp_t expected_pixels[$];
		int          errors;

		function new();
			rect = '0; clip = '0; blend = 1'b0; col = 0; row = 0; errors = 0;
			for (int k = 0; k < 4; k++) begin
				corner[k] = '0; top_acc[k] = '0; bot_acc[k] = '0;
				vstep[k] = '0; pix_acc[k] = '0; hstep[k] = '0; hstep[k+4] = '0;
			end
		endfunction

		function longint sx(logic [19:0] u);
			return longint'($signed(u));
		endfunction

		function longint chan(logic [31:0] c, int k);
			return longint'(c[8*k +: 8]);
		endfunction

		function longint clamp16(longint v);
			if (v < 0) return 0;
			if (v > 65535) return 65535;
			return v;
		endfunction

		function void write_reg(logic [2:0] idx, logic [47:0] v);
			case (idx)
				bgab_pkg::REG_COLOR_UL: corner[0] = v[31:0];
				bgab_pkg::REG_COLOR_UR: corner[1] = v[31:0];
				bgab_pkg::REG_COLOR_LL: corner[2] = v[31:0];
				bgab_pkg::REG_COLOR_LR: corner[3] = v[31:0];
				bgab_pkg::REG_RECT:     rect = v[25:0];
				bgab_pkg::REG_CLIP:     clip = v;
				bgab_pkg::REG_BLEND:    blend = v[0];
				default:                return;
			endcase
			col = 0;
			row = 0;
		endfunction

		function void note_request(bgab_pkg::dest_req_t d);
			longint   w, h, ox, oy, vt, vb, vs, a8, c, v;
			int       dw, dh;
			logic [7:0] dst[3];
			logic     solid;
			bgab_pkg::pix_rsp_t p;
			w = rect[12:0]; h = rect[25:13];
			ox = clip[11:0]; oy = clip[23:12];
			dw = clip[35:24]; dh = clip[47:36];
			// empty or oversize rectangle: nothing comes out
			if (w == 0 || h == 0 || w > bgab_pkg::MAX_DIM || h > bgab_pkg::MAX_DIM
				|| dw == 0 || dh == 0)
				return;
			if (col >= dw || row >= dh) begin
				col = 0; row = 0;
			end
			// frame start: horizontal steps and edge colours
			if (col == 0 && row == 0) begin
				for (int k = 0; k < 4; k++) begin
					vt = ((chan(corner[1], k) - chan(corner[0], k)) * 256) / w;
					vb = ((chan(corner[3], k) - chan(corner[2], k)) * 256) / w;
					hstep[k] = vt[19:0];
					hstep[k+4] = vb[19:0];
					top_acc[k] = 20'(chan(corner[0], k) * 256 + vt * ox);
					bot_acc[k] = 20'(chan(corner[2], k) * 256 + vb * ox);
				end
			end
			// column start: vertical steps
			if (row == 0) begin
				for (int k = 0; k < 4; k++) begin
					vs = (sx(bot_acc[k]) - sx(top_acc[k])) / h;
					vstep[k] = vs[19:0];
					pix_acc[k] = 20'(sx(top_acc[k]) + vs * oy);
				end
			end
			dst[0] = d.dest_red; dst[1] = d.dest_green; dst[2] = d.dest_blue;
			solid = (corner[0][23:0] == corner[1][23:0]) && (corner[0][23:0] == corner[2][23:0])
				&& (corner[0][23:0] == corner[3][23:0]);
			a8 = clamp16(sx(pix_acc[3])) >> 8;
			for (int k = 0; k < 3; k++) begin
				c = clamp16(sx(pix_acc[k]));
				if (blend && !solid)
					v = (c * a8 + (longint'(dst[k]) << 8) * (255 - a8)) >> 16;
				else
					v = c >> 8;
				case (k)
					0: p.out_red = v[7:0];
					1: p.out_green = v[7:0];
					default: p.out_blue = v[7:0];
				endcase
			end
			p.last_pixel = (col == dw - 1) && (row == dh - 1);
			expected_pixels.push_back(p);
			// advance position
			for (int k = 0; k < 4; k++)
				pix_acc[k] = 20'(sx(pix_acc[k]) + sx(vstep[k]));
			row++;
			if (row >= dh) begin
				row = 0;
				for (int k = 0; k < 4; k++) begin
					top_acc[k] = 20'(sx(top_acc[k]) + sx(hstep[k]));
					bot_acc[k] = 20'(sx(bot_acc[k]) + sx(hstep[k+4]));
				end
				col++;
				if (col >= dw) col = 0;
			end
		endfunction

		function void check_result(bgab_pkg::pix_rsp_t got);
			bgab_pkg::pix_rsp_t exp_p;
			if (expected_pixels.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected pixel %h", got);
				return;
			end
			exp_p = expected_pixels.pop_front();
			if (got.out_red !== exp_p.out_red || got.out_green !== exp_p.out_green ||
				got.out_blue !== exp_p.out_blue || got.last_pixel !== exp_p.last_pixel) begin
				errors++;
				if (errors <= 10)
					$display("pixel mismatch: expected r %h g %h b %h last %b, got r %h g %h b %h last %b",
						exp_p.out_red, exp_p.out_green, exp_p.out_blue, exp_p.last_pixel,
						got.out_red, got.out_green, got.out_blue, got.last_pixel);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	pixel_scoreboard sb = new();

	bgab_chan_if #(.T(bgab_pkg::cfg_req_t))  cfg_if ();
	bgab_chan_if #(.T(bgab_pkg::dest_req_t)) dest_if ();
	bgab_chan_if #(.T(bgab_pkg::pix_rsp_t))  pix_if ();

	bilinear_gradient_alpha_blend u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if.sink),
		.dest_in (dest_if.sink),
		.pix_out (pix_if.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// known values on every input from time zero
	initial begin
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		dest_if.valid = 1'b0;
		dest_if.data = '0;
		pix_if.ready = 1'b0;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (arst_n)
			pix_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watch accepted requests and results
	always @(posedge clk) begin
		if (dest_if.valid && dest_if.ready)
			sb.note_request(dest_if.data);
		if (pix_if.valid && pix_if.ready)
			sb.check_result(pix_if.data);
	end

	// one register write, then valid drops before the task returns
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] v);
		bgab_pkg::cfg_req_t r;
		r.index = idx;
		r.value = v;
		cfg_if.valid <= 1'b1;
		cfg_if.data <= r;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, v);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		bgab_pkg::dest_req_t d;
		d.dest_red = r; d.dest_green = g; d.dest_blue = b;
		if ($urandom_range(99) < send_idle_pct) begin
			dest_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		dest_if.valid <= 1'b1;
		dest_if.data <= d;
		do @(posedge clk); while (!dest_if.ready);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
				8'($urandom_range(255)));
	endtask

	// wait for every expected pixel, then let the block settle
	task automatic drain();
		dest_if.valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_QUIET) @(posedge clk);
	endtask

	function automatic logic [12:0] pick_dim();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 13'($urandom_range(1, 12));
		if (r < 85) return 13'($urandom_range(13, 64));
		if (r < 93) return 13'(bgab_pkg::MAX_DIM);
		if (r < 97) return 13'($urandom_range(bgab_pkg::MAX_DIM + 1, 8191));
		return 13'd0;
	endfunction

	function automatic logic [11:0] pick_drawn();
		int r;
		r = $urandom_range(99);
		if (r < 80) return 12'($urandom_range(1, 6));
		if (r < 90) return 12'($urandom_range(7, 40));
		return 12'($urandom_range(4095));
	endfunction

	function automatic logic [11:0] pick_offset(input logic [12:0] dim);
		if ($urandom_range(99) < 60) return 12'($urandom_range(dim));
		return 12'($urandom_range(4095));
	endfunction

	task automatic random_setup();
		logic [31:0] base;
		logic [12:0] w, h;
		base = $urandom;
		// corners, sometimes a solid fill with differing alpha
		if ($urandom_range(99) < 15) begin
			write_reg(bgab_pkg::REG_COLOR_UL, 48'({8'($urandom_range(255)), base[23:0]}));
			write_reg(bgab_pkg::REG_COLOR_UR, 48'({8'($urandom_range(255)), base[23:0]}));
			write_reg(bgab_pkg::REG_COLOR_LL, 48'({8'($urandom_range(255)), base[23:0]}));
			write_reg(bgab_pkg::REG_COLOR_LR, 48'({8'($urandom_range(255)), base[23:0]}));
		end else begin
			if ($urandom_range(1)) write_reg(bgab_pkg::REG_COLOR_UL, 48'($urandom));
			write_reg(bgab_pkg::REG_COLOR_UR, 48'($urandom));
			if ($urandom_range(1)) write_reg(bgab_pkg::REG_COLOR_LL, 48'($urandom));
			write_reg(bgab_pkg::REG_COLOR_LR, 48'($urandom));
		end
		w = pick_dim();
		h = pick_dim();
		write_reg(bgab_pkg::REG_RECT, 48'({h, w}));
		write_reg(bgab_pkg::REG_CLIP, {pick_drawn(), pick_drawn(), pick_offset(h), pick_offset(w)});
		write_reg(bgab_pkg::REG_BLEND, 48'({$urandom, $urandom}));
		if ($urandom_range(99) < 10) write_reg(UNUSED_REG_IDX, 48'({$urandom, $urandom}));
	endtask

	initial begin
		send_idle_pct = 15;
		recv_stall_pct = 76;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extreme colours, blend on, frame wraps past eight pixels
		write_reg(bgab_pkg::REG_COLOR_UL, 48'h0000_0000);
		write_reg(bgab_pkg::REG_COLOR_UR, 48'hFFFF_FFFF);
		write_reg(bgab_pkg::REG_COLOR_LL, 48'h80FF_00FF);
		write_reg(bgab_pkg::REG_COLOR_LR, 48'h0000_FF00);
		write_reg(bgab_pkg::REG_RECT, 48'({13'd4, 13'd4}));
		write_reg(bgab_pkg::REG_CLIP, {12'd2, 12'd4, 12'd0, 12'd0});
		write_reg(bgab_pkg::REG_BLEND, 48'd1);
		for (int i = 0; i < 10; i++)
			send_pixel(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, i[1] ? 8'hFF : 8'h00);
		drain();
		// solid fill ignores alpha even with blend on
		write_reg(bgab_pkg::REG_COLOR_UL, 48'h00_123456);
		write_reg(bgab_pkg::REG_COLOR_UR, 48'hFF_123456);
		write_reg(bgab_pkg::REG_COLOR_LL, 48'h7F_123456);
		write_reg(bgab_pkg::REG_COLOR_LR, 48'h01_123456);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		drain();
		// largest rectangle, offsets far out so colours saturate
		write_reg(bgab_pkg::REG_COLOR_UL, 48'hFF00_FF00);
		write_reg(bgab_pkg::REG_COLOR_UR, 48'h00FF_00FF);
		write_reg(bgab_pkg::REG_COLOR_LR, 48'hFFFF_FFFF);
		write_reg(bgab_pkg::REG_RECT, 48'({13'(bgab_pkg::MAX_DIM), 13'(bgab_pkg::MAX_DIM)}));
		write_reg(bgab_pkg::REG_CLIP, {12'd2, 12'd2, 12'hFFF, 12'hFFF});
		send_random(4);
		drain();
		write_reg(bgab_pkg::REG_BLEND, 48'd0);
		send_random(2);
		drain();
		// empty rectangle: requests taken, nothing produced
		write_reg(bgab_pkg::REG_RECT, 48'({13'd5, 13'd0}));
		send_random(3);
		drain();
		// unused index leaves state and position alone
		write_reg(bgab_pkg::REG_RECT, 48'({13'd3, 13'd3}));
		send_random(1);
		drain();
		write_reg(UNUSED_REG_IDX, 48'hFFFF_FFFF_FFFF);
		send_random(3);
		drain();

		// random phases
		for (int p = 0; p < 17; p++) begin
			if (p < 6) begin
				send_idle_pct = 15; recv_stall_pct = 76;
			end else if (p < 12) begin
				send_idle_pct = 76; recv_stall_pct = 15;
			end else begin
				send_idle_pct = 0; recv_stall_pct = 0;
			end
			random_setup();
			send_random(30);
			// sender holds off until the block has caught up
			dest_if.valid <= 1'b0;
			while (sb.expected_pixels.size() != 0) @(posedge clk);
			send_random(30);
			drain();
		end

		if (sb.expected_pixels.size() != 0) sb.errors += sb.expected_pixels.size();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// overall time limit
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/bgab_pkg.sv
rtl/core/bgab_chan_if.sv
rtl/core/bilinear_gradient_alpha_blend.sv
verif/bilinear_gradient_alpha_blend_test.sv
